// File: rtl/nwc_pkg.sv
// shared types and constants for the normalized window convolution unit
`timescale 1ns / 1ps
package nwc_pkg;
    localparam int NUM_COEF   = 25;
    localparam int COEF_VEC_W = 8 * NUM_COEF;
    localparam int KSUM_W     = 13;
    localparam int RES_W      = 21;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [RES_W-1:0] OUT_LIMIT = 21'd1048575;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MODE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_C       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_D       = 3'd6;

    typedef struct packed {
        logic [11:0] width;
        logic [10:0] height;
        logic [1:0]  radius;
    } t_geom;

    typedef struct packed {
        logic [9:0] out_col;
        logic [9:0] out_row;
        logic       inner;
        logic       last;
    } t_job_meta;

    localparam int META_W = $bits(t_job_meta);
endpackage

// File: rtl/normalized_window_convolution_unit.sv
// top level of the normalized window convolution unit: configuration and assembly
`timescale 1ns / 1ps
// Raster pixels enter through a queue-style port (push/full) and results leave through
// one (empty/pop), one result per pixel once radius rows plus radius pixels of a frame
// have arrived. The front end reads the line store for a pixel and then updates the
// window before it takes the next pixel. The back end gives zero for a border output;
// for an interior one it steps the one multiplier over the taps, where taps is 9
// (3x3) or 25 (5x5), then runs the bit-serial divider over the ACC_W-bit magnitude,
// with ACC_W = PIXEL_BITS + COEF_BITS + 6, and skips the divider when the coefficient
// sum is zero. A two-entry job queue lets the front end run ahead. The line store is
// undefined after reset.
module normalized_window_convolution_unit
    import nwc_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 2,
    parameter int PIXEL_BITS = 8,
    parameter int COEF_BITS  = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    push,
    output logic                    full,
    input  logic [7:0]              i_pixel_in,
    input  logic                    i_frame_start,
    output logic                    empty,
    input  logic                    pop,
    output logic [9:0]              o_out_col,
    output logic [9:0]              o_out_row,
    output logic signed [RES_W-1:0] o_filtered,
    output logic                    o_frame_last
);
    localparam int WIN_BITS = (2 * MAX_RADIUS + 1) ** 2 * PIXEL_BITS;
    localparam int JOB_W    = WIN_BITS + META_W;

    logic [10:0]            r_frame_width;
    logic [10:0]            r_frame_height;
    logic                   r_kernel_mode;
    logic [63:0]            r_coef_a;
    logic [63:0]            r_coef_b;
    logic [63:0]            r_coef_c;
    logic [7:0]             r_coef_d;

    t_geom                  geom;
    logic [COEF_VEC_W-1:0]  coefs;
    logic                   job_push;
    logic                   job_full;
    logic                   job_pop;
    logic                   job_empty;
    logic [WIN_BITS-1:0]    front_win;
    t_job_meta              front_meta;
    logic [JOB_W-1:0]       head;
    t_job_meta              head_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 11'd640;
            r_frame_height <= 11'd480;
            r_kernel_mode  <= 1'b0;
            r_coef_a       <= '0;
            r_coef_b       <= '0;
            r_coef_c       <= '0;
            r_coef_d       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[10:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[10:0];
                CFG_KERNEL_MODE:  r_kernel_mode  <= i_cfg_data[0];
                CFG_COEF_A:       r_coef_a       <= i_cfg_data;
                CFG_COEF_B:       r_coef_b       <= i_cfg_data;
                CFG_COEF_C:       r_coef_c       <= i_cfg_data;
                CFG_COEF_D:       r_coef_d       <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_frame_width == '0) begin
            geom.width = 12'd1;
        end else if ({2'b0, r_frame_width} > 13'(MAX_WIDTH)) begin
            geom.width = 12'(MAX_WIDTH);
        end else begin
            geom.width = {1'b0, r_frame_width};
        end
        if (r_frame_height == '0) begin
            geom.height = 11'd1;
        end else if (r_frame_height > 11'd1024) begin
            geom.height = 11'd1024;
        end else begin
            geom.height = r_frame_height;
        end
        geom.radius = (r_kernel_mode && MAX_RADIUS >= 2) ? 2'd2 : 2'd1;
    end

    assign coefs = {r_coef_d, r_coef_c, r_coef_b, r_coef_a};

    nwc_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_RADIUS(MAX_RADIUS),
        .PIXEL_BITS(PIXEL_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_geom       (geom),
        .i_push       (push),
        .o_full       (full),
        .i_pixel_in   (i_pixel_in),
        .i_frame_start(i_frame_start),
        .o_job_push   (job_push),
        .i_job_full   (job_full),
        .o_job_win    (front_win),
        .o_job_meta   (front_meta)
    );

    nwc_job_queue #(
        .DATA_W(JOB_W)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (job_push),
        .i_data ({front_win, front_meta}),
        .o_full (job_full),
        .i_pop  (job_pop),
        .o_data (head),
        .o_empty(job_empty)
    );

    assign head_meta = head[META_W-1:0];

    nwc_back #(
        .MAX_RADIUS(MAX_RADIUS),
        .PIXEL_BITS(PIXEL_BITS),
        .COEF_BITS (COEF_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_radius    (geom.radius),
        .i_coefs     (coefs),
        .i_job_empty (job_empty),
        .i_job_win   (head[JOB_W-1:META_W]),
        .i_job_meta  (head_meta),
        .o_job_pop   (job_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_out_col   (o_out_col),
        .o_out_row   (o_out_row),
        .o_filtered  (o_filtered),
        .o_frame_last(o_frame_last)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_push |-> !job_full) else $error("job pushed into full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_pop |-> !job_empty) else $error("job popped from empty queue");

    a_result_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_filtered <= $signed(OUT_LIMIT)) && (o_filtered >= -$signed(OUT_LIMIT)))
        else $error("result outside saturation range");

    a_edge_col_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_out_col == '0 || o_out_row == '0)) |-> (o_filtered == '0))
        else $error("border result not zero");
endmodule

// File: rtl/nwc_front.sv
// front end: pixel intake, position tracking, line store and window register
`timescale 1ns / 1ps
module nwc_front
    import nwc_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 2,
    parameter int PIXEL_BITS = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  t_geom                                  i_geom,
    input  logic                                   i_push,
    output logic                                   o_full,
    input  logic [7:0]                             i_pixel_in,
    input  logic                                   i_frame_start,
    output logic                                   o_job_push,
    input  logic                                   i_job_full,
    output logic [(2*MAX_RADIUS+1)**2*PIXEL_BITS-1:0] o_job_win,
    output t_job_meta                              o_job_meta
);
    localparam int WIN   = 2 * MAX_RADIUS + 1;
    localparam int NWIN  = WIN * WIN;
    localparam int LROWS = 2 * MAX_RADIUS;
    localparam int PB    = PIXEL_BITS;
    localparam int COL_W = $clog2(MAX_WIDTH);

    typedef enum logic [1:0] {
        F_IDLE = 2'b01,
        F_LOAD = 2'b10
    } t_front_state;

    t_front_state           r_state;
    logic [COL_W-1:0]       r_col;
    logic [9:0]             r_row;
    logic [COL_W-1:0]       r_c;
    logic [PB-1:0]          r_pix;
    t_job_meta              r_meta;
    logic                   r_emit;
    logic [LROWS*PB-1:0]    r_rd_data;
    logic [PB-1:0]          r_win [NWIN];
    logic [PB-1:0]          n_win [NWIN];
    logic [PB-1:0]          colv [WIN];
    logic [LROWS*PB-1:0]    wr_data;
    logic [LROWS*PB-1:0]    mem [MAX_WIDTH];

    logic                   accept;
    logic                   load_go;
    logic [12:0]            w13;
    logic [12:0]            c_pre;
    logic [10:0]            row_pre;
    logic [12:0]            c_nx;
    logic [10:0]            row_nx;
    logic signed [13:0]     t_col;
    logic signed [13:0]     t_row;
    logic signed [13:0]     rad_s;
    logic signed [13:0]     w_s;
    logic signed [13:0]     h_s;
    logic                   last;
    logic                   emit;
    logic                   inner;

    assign accept  = i_push && (r_state == F_IDLE);
    assign load_go = (r_state == F_LOAD) && (!r_emit || !i_job_full);
    assign o_full  = (r_state != F_IDLE);
    assign w13     = {1'b0, i_geom.width};
    assign rad_s   = $signed({12'b0, i_geom.radius});
    assign w_s     = $signed({2'b0, i_geom.width});
    assign h_s     = $signed({3'b0, i_geom.height});

    // position of this pixel and of the output it completes
    always_comb begin
        c_pre   = 13'(r_col);
        row_pre = {1'b0, r_row};
        if (i_frame_start) begin
            c_pre   = '0;
            row_pre = '0;
        end
        if (c_pre >= w13) begin
            c_pre   = '0;
            row_pre = row_pre + 11'd1;
        end
        if (row_pre >= i_geom.height) begin
            row_pre = '0;
        end
        last   = (c_pre == w13 - 13'd1) && (row_pre == i_geom.height - 11'd1);
        c_nx   = c_pre + 13'd1;
        row_nx = row_pre;
        if (c_nx >= w13) begin
            c_nx   = '0;
            row_nx = row_pre + 11'd1;
            if (row_nx >= i_geom.height) begin
                row_nx = '0;
            end
        end
        t_col = $signed({1'b0, c_pre}) - rad_s;
        t_row = $signed({3'b0, row_pre}) - rad_s;
        if (t_col < 0) begin
            t_col = t_col + w_s;
            t_row = t_row - 14'sd1;
        end
        if (t_col < 0) begin
            t_col = t_col + w_s;
            t_row = t_row - 14'sd1;
        end
        emit  = (t_row >= 0);
        inner = (t_col >= rad_s) && (t_col + rad_s < w_s)
             && (t_row >= rad_s) && (t_row + rad_s < h_s);
    end

    // new column and shifted window
    always_comb begin
        for (int k = 0; k < LROWS; k++) begin
            colv[k] = r_rd_data[k*PB +: PB];
        end
        colv[LROWS] = r_pix;
        for (int k = 0; k < LROWS; k++) begin
            wr_data[k*PB +: PB] = colv[k+1];
        end
        for (int i = 0; i < WIN; i++) begin
            for (int j = 0; j < WIN - 1; j++) begin
                n_win[i*WIN+j] = r_win[i*WIN+j+1];
            end
            n_win[i*WIN+WIN-1] = colv[i];
        end
        for (int e = 0; e < NWIN; e++) begin
            o_job_win[e*PB +: PB] = n_win[e];
        end
    end

    assign o_job_push = load_go && r_emit;
    assign o_job_meta = r_meta;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_data <= mem[c_pre[COL_W-1:0]];
        end
        if (load_go) begin
            mem[r_c] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_c            <= c_pre[COL_W-1:0];
            r_pix          <= PB'(i_pixel_in);
            r_emit         <= emit;
            r_meta.out_col <= t_col[9:0];
            r_meta.out_row <= t_row[9:0];
            r_meta.inner   <= inner;
            r_meta.last    <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            for (int e = 0; e < NWIN; e++) begin
                r_win[e] <= '0;
            end
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        r_col   <= c_nx[COL_W-1:0];
                        r_row   <= row_nx[9:0];
                        r_state <= F_LOAD;
                    end
                end
                F_LOAD: begin
                    if (load_go) begin
                        r_win   <= n_win;
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end
endmodule

// File: rtl/nwc_job_queue.sv
// two-entry queue of window jobs between front and back end
`timescale 1ns / 1ps
module nwc_job_queue
    import nwc_pkg::*;
#(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty
);
    logic [DATA_W-1:0] r_data [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_data[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_data[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wp <= ~r_wp;
            end
            if (i_pop && !o_empty) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push && !o_full} - {1'b0, i_pop && !o_empty};
        end
    end
endmodule

// File: rtl/nwc_back.sv
// back end: window multiply-accumulate, divide by nonzero coefficient sum, result register
`timescale 1ns / 1ps
module nwc_back
    import nwc_pkg::*;
#(
    parameter int MAX_RADIUS = 2,
    parameter int PIXEL_BITS = 8,
    parameter int COEF_BITS  = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [1:0]                             i_radius,
    input  logic [COEF_VEC_W-1:0]                  i_coefs,
    input  logic                                   i_job_empty,
    input  logic [(2*MAX_RADIUS+1)**2*PIXEL_BITS-1:0] i_job_win,
    input  t_job_meta                              i_job_meta,
    output logic                                   o_job_pop,
    output logic                                   o_empty,
    input  logic                                   i_pop,
    output logic [9:0]                             o_out_col,
    output logic [9:0]                             o_out_row,
    output logic signed [RES_W-1:0]                o_filtered,
    output logic                                   o_frame_last
);
    localparam int WIN    = 2 * MAX_RADIUS + 1;
    localparam int NWIN   = WIN * WIN;
    localparam int PB     = PIXEL_BITS;
    localparam int EB     = $clog2(NWIN);
    localparam int PROD_W = PB + 1 + COEF_BITS;
    localparam int ACC_W  = PB + COEF_BITS + 6;
    localparam int MAG_W  = (ACC_W > RES_W) ? ACC_W : RES_W;
    localparam int CNT_W  = $clog2(ACC_W + 1);

    typedef enum logic [5:0] {
        B_IDLE  = 6'b000001,
        B_MAC   = 6'b000010,
        B_DRAIN = 6'b000100,
        B_DIV   = 6'b001000,
        B_FIN   = 6'b010000,
        B_DONE  = 6'b100000
    } t_back_state;

    t_back_state                r_state;
    logic [2:0]                 r_i;
    logic [2:0]                 r_j;
    logic [4:0]                 r_t;
    logic [EB-1:0]              r_e;
    logic                       r_pv;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [KSUM_W-1:0]   r_ksum;
    logic [ACC_W-1:0]           r_dvd;
    logic [KSUM_W-1:0]          r_dvs;
    logic [KSUM_W-1:0]          r_rem;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_neg;
    logic signed [RES_W-1:0]    r_res;
    logic                       r_ov;

    logic [PB-1:0]              win_arr [NWIN];
    logic [2:0]                 side;
    logic [EB-1:0]              e_start;
    logic [EB-1:0]              e_jump;
    logic [7:0]                 coef_byte;
    logic signed [COEF_BITS-1:0] coef_s;
    logic signed [PB:0]         pix_s;
    logic signed [ACC_W-1:0]    total;
    logic [ACC_W-1:0]           total_mag;
    logic [KSUM_W:0]            rem_sh;
    logic [MAG_W-1:0]           mag_w;
    logic [RES_W-1:0]           mag_sat;
    logic                       tap_last;
    logic                       out_load;

    always_comb begin
        for (int e = 0; e < NWIN; e++) begin
            win_arr[e] = i_job_win[e*PB +: PB];
        end
    end

    assign side      = {i_radius, 1'b1};
    assign e_start   = EB'((WIN - int'(side)) * (WIN + 1));
    assign e_jump    = EB'(WIN - int'(side) + 1);
    assign coef_byte = i_coefs[{r_t, 3'b000} +: 8];
    assign coef_s    = $signed(coef_byte[COEF_BITS-1:0]);
    assign pix_s     = $signed({1'b0, win_arr[r_e]});
    assign tap_last  = (r_i == side - 3'd1) && (r_j == side - 3'd1);
    assign total     = r_acc + ACC_W'(r_prod);
    assign total_mag = total[ACC_W-1] ? ACC_W'(-total) : ACC_W'(total);
    assign rem_sh    = {r_rem, r_dvd[ACC_W-1]};
    assign mag_w     = MAG_W'(r_dvd);
    assign mag_sat   = (mag_w > MAG_W'(OUT_LIMIT)) ? OUT_LIMIT : mag_w[RES_W-1:0];
    assign out_load  = (r_state == B_DONE) && (!r_ov || i_pop);
    assign o_job_pop = out_load;
    assign o_empty   = !r_ov;

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                r_i    <= '0;
                r_j    <= '0;
                r_t    <= '0;
                r_e    <= e_start;
                r_acc  <= '0;
                r_ksum <= '0;
                r_res  <= '0;
            end
            B_MAC: begin
                r_prod <= pix_s * coef_s;
                if (r_pv) begin
                    r_acc <= r_acc + ACC_W'(r_prod);
                end
                r_ksum <= r_ksum + KSUM_W'(coef_s);
                r_t    <= r_t + 5'd1;
                if (r_j == side - 3'd1) begin
                    r_j <= '0;
                    r_i <= r_i + 3'd1;
                    r_e <= r_e + e_jump;
                end else begin
                    r_j <= r_j + 3'd1;
                    r_e <= r_e + EB'(1);
                end
            end
            B_DRAIN: begin
                r_dvd <= total_mag;
                r_neg <= (r_ksum == '0) ? total[ACC_W-1]
                                        : (total[ACC_W-1] ^ r_ksum[KSUM_W-1]);
                r_dvs <= r_ksum[KSUM_W-1] ? KSUM_W'(-r_ksum) : KSUM_W'(r_ksum);
                r_rem <= '0;
                r_cnt <= CNT_W'(ACC_W);
            end
            B_DIV: begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (rem_sh >= {1'b0, r_dvs}) begin
                    r_rem <= KSUM_W'(rem_sh - {1'b0, r_dvs});
                    r_dvd <= {r_dvd[ACC_W-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[KSUM_W-1:0];
                    r_dvd <= {r_dvd[ACC_W-2:0], 1'b0};
                end
            end
            B_FIN: begin
                r_res <= r_neg ? $signed(-mag_sat) : $signed(mag_sat);
            end
            B_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_out_col    <= i_job_meta.out_col;
            o_out_row    <= i_job_meta.out_row;
            o_frame_last <= i_job_meta.last;
            o_filtered   <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    r_pv <= 1'b0;
                    if (!i_job_empty) begin
                        r_state <= i_job_meta.inner ? B_MAC : B_DONE;
                    end
                end
                B_MAC: begin
                    r_pv <= 1'b1;
                    if (tap_last) begin
                        r_state <= B_DRAIN;
                    end
                end
                B_DRAIN: begin
                    r_state <= (r_ksum == '0) ? B_FIN : B_DIV;
                end
                B_DIV: begin
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= B_FIN;
                    end
                end
                B_FIN: begin
                    r_state <= B_DONE;
                end
                B_DONE: begin
                    if (out_load) begin
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end
endmodule

// File: test/tb.sv
// self-checking testbench for the normalized window convolution unit
`timescale 1ns / 1ps
module tb;
    import nwc_pkg::*;

    typedef struct {
        logic [9:0]              col;
        logic [9:0]              row;
        logic signed [RES_W-1:0] filt;
        logic                    last;
    } t_pix_result;

    typedef struct {
        logic [7:0] pix;
        logic       fs;
        bit         chk;
        int         filt;
    } t_stim_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                    push = 1'b0;
    logic                    full;
    logic [7:0]              i_pixel_in = '0;
    logic                    i_frame_start = 1'b0;
    logic                    empty;
    logic                    pop = 1'b0;
    logic [9:0]              o_out_col;
    logic [9:0]              o_out_row;
    logic signed [RES_W-1:0] o_filtered;
    logic                    o_frame_last;

    normalized_window_convolution_unit dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    logic [10:0] m_width = 11'd640, m_height = 11'd480;
    logic        m_mode = 1'b0;
    logic [63:0] m_coef_a = '0, m_coef_b = '0, m_coef_c = '0;
    logic [7:0]  m_coef_d = '0;
    int          line_rows[4][1024];
    int          win_pix[5][5];
    int unsigned col_pos = 0, row_pos = 0, cols_seen = 0;

    t_pix_result result_q[$];
    t_stim_row   stim[$];
    int          errors = 0;
    int          rand_items = 0;
    int          tx_idle = 9, rx_idle = 60;
    logic        rx_hold = 1'b0;

    function automatic int coef_of(int k);
        logic [7:0] b;
        if (k < 8) b = m_coef_a[8*(k%8) +: 8];
        else if (k < 16) b = m_coef_b[8*(k%8) +: 8];
        else if (k < 24) b = m_coef_c[8*(k%8) +: 8];
        else b = m_coef_d;
        return int'($signed(b));
    endfunction

    task automatic predict_pixel(input logic [7:0] pix, input logic fs);
        int unsigned w, h, r, side, c, rw, oc, orow;
        int colv[5];
        longint q, d, p, total, res;
        int ksum;
        t_pix_result e;
        w = (m_width < 1) ? 1 : ((m_width > 1024) ? 1024 : m_width);
        h = (m_height < 1) ? 1 : ((m_height > 1024) ? 1024 : m_height);
        r = m_mode ? 2 : 1;
        side = 2 * r + 1;
        ksum = 0;
        for (int k = 0; k < side * side; k++) ksum += coef_of(k);
        if (fs) begin
            col_pos = 0;
            row_pos = 0;
        end
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) row_pos = 0;
        c = col_pos;
        rw = row_pos;
        for (int k = 0; k < 4; k++) colv[k] = line_rows[k][c];
        colv[4] = pix;
        for (int i = 0; i < 5; i++) begin
            for (int j = 0; j < 4; j++) win_pix[i][j] = win_pix[i][j+1];
            win_pix[i][4] = colv[i];
        end
        for (int k = 0; k < 4; k++) line_rows[k][c] = colv[k+1];
        if (c + 1 > cols_seen) cols_seen = c + 1;
        e.last = (c == w - 1) && (rw == h - 1);
        col_pos = c + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = rw + 1;
            if (row_pos >= h) row_pos = 0;
        end
        q = longint'(rw) * w + c;
        d = longint'(r) * w + r;
        if (q < d) return;
        p = q - d;
        oc = p % w;
        orow = p / w;
        res = 0;
        if (oc >= r && oc + r < w && orow >= r && orow + r < h) begin
            total = 0;
            for (int i = 0; i < side; i++)
                for (int j = 0; j < side; j++)
                    total += longint'(win_pix[5-side+i][5-side+j]) * coef_of(i * side + j);
            res = (ksum != 0) ? total / ksum : total;
            if (res > 1048575) res = 1048575;
            if (res < -1048575) res = -1048575;
        end
        e.col = oc[9:0];
        e.row = orow[9:0];
        e.filt = res[RES_W-1:0];
        result_q.insert(result_q.size(), e);
    endtask

    task automatic add_stim(input logic [7:0] pix, input logic fs, input bit chk,
                            input int filt);
        t_stim_row s;
        s.pix = pix;
        s.fs = fs;
        s.chk = chk;
        s.filt = filt;
        stim.insert(stim.size(), s);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_FRAME_WIDTH:  m_width = data[10:0];
            CFG_FRAME_HEIGHT: m_height = data[10:0];
            CFG_KERNEL_MODE:  m_mode = data[0];
            CFG_COEF_A:       m_coef_a = data;
            CFG_COEF_B:       m_coef_b = data;
            CFG_COEF_C:       m_coef_c = data;
            CFG_COEF_D:       m_coef_d = data[7:0];
            default: ;
        endcase
    endtask

    task automatic set_frame(input logic [10:0] w, input logic [10:0] h, input logic mode,
                             input logic [7:0] cb[25]);
        cfg_write(CFG_FRAME_WIDTH, 64'(w));
        cfg_write(CFG_FRAME_HEIGHT, 64'(h));
        cfg_write(CFG_KERNEL_MODE, 64'(mode));
        cfg_write(CFG_COEF_A, {cb[7], cb[6], cb[5], cb[4], cb[3], cb[2], cb[1], cb[0]});
        cfg_write(CFG_COEF_B, {cb[15], cb[14], cb[13], cb[12], cb[11], cb[10], cb[9], cb[8]});
        cfg_write(CFG_COEF_C, {cb[23], cb[22], cb[21], cb[20], cb[19], cb[18], cb[17], cb[16]});
        cfg_write(CFG_COEF_D, 64'(cb[24]));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // one pixel transfer; a typed value replaces the predicted one where given
    task automatic send_pixel(input logic [7:0] pix, input logic fs, input bit chk = 0,
                              input int filt = 0);
        int n;
        while ($urandom_range(99) < tx_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_pixel_in <= pix;
        i_frame_start <= fs;
        do @(posedge i_clk); while (full);
        n = result_q.size();
        predict_pixel(pix, fs);
        if (chk && result_q.size() > n) result_q[$].filt = filt[RES_W-1:0];
    endtask

    task automatic drain;
        push <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_pix_result e;
        if (pop && !empty) begin
            if (result_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result col %0d row %0d filt %0d", o_out_col,
                             o_out_row, o_filtered);
            end else begin
                e = result_q.pop_front();
                if (o_out_col !== e.col || o_out_row !== e.row || o_filtered !== e.filt ||
                    o_frame_last !== e.last) begin
                    errors++;
                    if (errors <= 10)
                        $display(
                            "mismatch: exp col %0d row %0d filt %0d last %0b, got %0d %0d %0d %0b",
                            e.col, e.row, e.filt, e.last, o_out_col, o_out_row,
                            o_filtered, o_frame_last);
                end
            end
        end
        pop <= !rx_hold && ($urandom_range(99) >= rx_idle);
    end

    // long receiver stall so the input side backs up
    initial begin
        wait (rand_items > 250);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (800) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin
        #20ms;
        $display("[normalized_window_convolution_unit] ERROR");
        $finish;
    end

    initial begin
        logic [7:0] cb[25];
        int unsigned w, h, n, kind, v;
        logic        mode, fs;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // box 3x3 on a 3x3 frame: only the center is interior
        foreach (cb[k]) cb[k] = 8'd1;
        set_frame(11'd3, 11'd3, 1'b0, cb);
        for (int k = 0; k < 9; k++) add_stim(8'd255, k == 0, k >= 4, (k == 8) ? 255 : 0);
        for (int k = 0; k < 9; k++) add_stim(8'd0, k == 0, k >= 4, 0);
        add_stim(8'd128, 1'b1, 0, 0);
        add_stim(8'd1, 1'b0, 0, 0);
        add_stim(8'd254, 1'b0, 0, 0);
        add_stim(8'd0, 1'b0, 0, 0);
        add_stim(8'd255, 1'b0, 0, 0);
        foreach (stim[i]) send_pixel(stim[i].pix, stim[i].fs, stim[i].chk, stim[i].filt);
        drain();

        // widest row, clamped: no output before the second row
        foreach (cb[k]) cb[k] = 8'($urandom_range(0, 255));
        set_frame(11'd2047, 11'd3, 1'b0, cb);
        for (int k = 0; k < 300; k++) send_pixel(8'($urandom_range(0, 255)), k == 0);
        drain();
        // single column, tallest frame, all border
        set_frame(11'd0, 11'd2047, 1'b1, cb);
        for (int k = 0; k < 60; k++) send_pixel(8'($urandom_range(0, 255)), k == 0);
        drain();
        // single pixel frames
        set_frame(11'd1, 11'd0, 1'b1, cb);
        for (int k = 0; k < 6; k++) send_pixel(8'($urandom_range(0, 255)), 1'b0);
        drain();
        // full frame over every column that later frames read
        set_frame(11'd24, 11'd5, 1'b1, cb);
        for (int k = 0; k < 120; k++) send_pixel(8'($urandom_range(0, 255)), k == 0);
        drain();

        while (rand_items < 600) begin
            tx_idle <= (rand_items < 200) ? 9 : ((rand_items < 400) ? 60 : 0);
            rx_idle <= (rand_items < 200) ? 60 : ((rand_items < 400) ? 9 : 0);
            w = ($urandom_range(9) == 0) ? $urandom_range(1, 24) : $urandom_range(3, 10);
            h = $urandom_range(1, 8);
            mode = $urandom_range(1);
            kind = $urandom_range(5);
            v = $urandom_range(1, 127);
            foreach (cb[k]) begin
                case (kind)
                    0: cb[k] = 8'd127;
                    1: cb[k] = 8'h80;
                    2: cb[k] = 8'($urandom_range(0, 3));
                    3: cb[k] = (k % 2 == 0) ? 8'(v) : 8'(-v);
                    default: cb[k] = 8'($urandom_range(0, 255));
                endcase
            end
            // zero coefficient sum: pairs cancel, last tap zero
            if (kind == 3) begin
                if (mode) cb[24] = 8'd0;
                else cb[8] = 8'd0;
            end
            set_frame(11'(w), 11'(h), mode, cb);
            n = $urandom_range(1, 3) * w * h + $urandom_range(0, w * h);
            if (n > 300) n = 300;
            fs = (w > cols_seen) || ($urandom_range(3) != 0);
            for (int k = 0; k < n; k++) begin
                send_pixel(8'($urandom_range(0, 255)), (k == 0) ? fs :
                           ($urandom_range(49) == 0));
                rand_items++;
            end
            drain();
        end

        if (errors == 0)
            $display("[normalized_window_convolution_unit] OK");
        else
            $display("[normalized_window_convolution_unit] ERROR");
        $finish;
    end
endmodule
